[rtl/stlu_pkg.sv]
// Shared types and constants of the shuffled three-LCG uniform integer generator.
package stlu_pkg;

    localparam int TABLE_DEPTH = 97;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LANES       = 3;

    localparam logic [17:0] MOD1 = 18'd259200;
    localparam logic [17:0] MOD2 = 18'd134456;
    localparam logic [17:0] MOD3 = 18'd243000;

    localparam logic [12:0] LCG_MUL [LANES] = '{13'd7141, 13'd8121, 13'd4561};
    localparam logic [15:0] LCG_INC [LANES] = '{16'd54773, 16'd28411, 16'd51349};
    localparam logic [17:0] LCG_MOD [LANES] = '{MOD1, MOD2, MOD3};

    // Reciprocals for exact floor division of operands below 2^31.
    localparam int          RCP_SHIFT = 49;
    localparam logic [63:0] RCP1_W = ((64'd1 << RCP_SHIFT) + 64'(MOD1) - 64'd1) / 64'(MOD1);
    localparam logic [63:0] RCP2_W = ((64'd1 << RCP_SHIFT) + 64'(MOD2) - 64'd1) / 64'(MOD2);
    localparam logic [63:0] RCP3_W = ((64'd1 << RCP_SHIFT) + 64'(MOD3) - 64'd1) / 64'(MOD3);
    localparam logic [31:0] LCG_RCP [LANES] = '{RCP1_W[31:0], RCP2_W[31:0], RCP3_W[31:0]};

    // The seed is folded below 2^31 before reduction.
    localparam int          SEED_SPLIT = 18;
    localparam logic [63:0] SEED_FOLD_W = (64'd1 << SEED_SPLIT) % 64'(MOD1);
    localparam logic [17:0] SEED_FOLD = SEED_FOLD_W[17:0];
    localparam logic [15:0] SEED_INC  = 16'd54773;
    localparam logic [31:0] SEED_RESET = 32'd3;

    // Table index is floor(TABLE_DEPTH * third / MOD3).
    localparam int          IDX_SHIFT = 36;
    localparam logic [63:0] IDX_RCP_W =
        ((64'(TABLE_DEPTH) << IDX_SHIFT) + 64'(MOD3) - 64'd1) / 64'(MOD3);
    localparam logic [26:0] IDX_RCP = IDX_RCP_W[26:0];

    localparam logic [35:0] DENOM  = 36'(64'(MOD1) * 64'(MOD2));

    localparam int RANGE_W = 33;
    localparam int HALF_W  = 16;

    // A dividend below 2^53 is divided by DENOM from its top 32 bits; the estimate
    // is at most one short and one compare and subtract corrects it.
    localparam int          DVD_W     = 53;
    localparam int          EST_LSB   = DVD_W - 32;
    localparam int          EST_SHIFT = 46;
    localparam logic [67:0] EST_RCP_W = (68'd1 << (EST_LSB + EST_SHIFT)) / 68'(DENOM);
    localparam logic [31:0] EST_RCP   = EST_RCP_W[31:0];

    typedef struct packed {
        logic signed [31:0] low_bound;
        logic signed [31:0] high_bound;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [35:0]        sample_numerator;
        logic               range_error;
    } rsp_t;

endpackage

[rtl/shuffled_triple_lcg_uniform_int.sv]
// Each item passes through the LCG reduction, the table read and the two-pass reciprocal
// scaling; the scaling is skipped when high_bound is below low_bound. A new item is
// accepted only once the previous result has been handed to the output register.
// The first item after reset or a seed write first fills the 97-entry table.
// Reset clears the control state, sets the seed to 3 and marks the generator unseeded;
// table contents are undefined until that first fill.
module shuffled_triple_lcg_uniform_int
    import stlu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  req_t        s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_QUO, ST_REM, ST_FILL, ST_IDX, ST_READ, ST_DRAW,
        ST_HMUL, ST_EST, ST_SUB, ST_FIX, ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_SEED_T, PH_SEED_A, PH_SEED_B, PH_FILL, PH_REQ
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    logic [31:0]      seed_reg;
    logic             seeded_reg;
    logic [17:0]      x_reg [LANES];
    logic [30:0]      prod_reg [LANES];
    logic [13:0]      quo_reg [LANES];
    logic [IDX_W-1:0] fill_cnt_reg;
    logic [IDX_W-1:0] idx_reg;
    req_t             req_reg;
    logic [35:0]      drawn_reg;
    logic [35:0]      rd_data_reg;
    logic [RANGE_W-1:0] n_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [51:0]      low_prod_reg;
    logic [16:0]      qe_reg;
    logic [36:0]      rem_reg;
    logic [16:0]      q_hi_reg;
    logic             pass_reg;
    logic [31:0]      acc_reg;
    logic             err_reg;
    logic             m_valid_reg;
    rsp_t             m_data_reg;

    logic [35:0] shuffle_mem [TABLE_DEPTH];

    logic [30:0]      lane_prod [LANES];
    logic [13:0]      lane_quo [LANES];
    logic [17:0]      lane_rem [LANES];
    logic [LANES-1:0] lane_en;
    logic [30:0]      seed_fold;
    logic [63:0]      idx_prod;
    logic [7:0]       idx_full;
    logic [IDX_W-1:0] idx_sel;
    logic [35:0]      frac_w;
    logic [RANGE_W-1:0] range_w;
    logic             range_err;
    logic [63:0]      est_prod;
    logic [53:0]      est_back;
    logic [16:0]      fix_q;
    logic [35:0]      fix_r;
    logic [32:0]      q_sum;
    logic [31:0]      result_w;
    logic             out_free;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_addr;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            lane_prod[i] = 31'({18'd0, LCG_MUL[i]}) * 31'(x_reg[i]) + 31'(LCG_INC[i]);
            lane_quo[i]  = 14'((64'(prod_reg[i]) * 64'(LCG_RCP[i])) >> RCP_SHIFT);
            lane_rem[i]  = 18'(prod_reg[i] - 31'(32'(quo_reg[i]) * 32'(LCG_MOD[i])));
        end
    end

    always_comb begin
        case (phase_reg)
            PH_REQ:  lane_en = 3'b111;
            PH_FILL: lane_en = 3'b011;
            default: lane_en = 3'b001;
        endcase
    end

    assign seed_fold = 31'(seed_reg[31:SEED_SPLIT]) * 31'(SEED_FOLD)
                     + 31'(seed_reg[SEED_SPLIT-1:0]) + 31'(SEED_INC);

    assign idx_prod = 64'(x_reg[2]) * 64'(IDX_RCP);
    assign idx_full = idx_prod[IDX_SHIFT +: 8];
    assign idx_sel  = (idx_full >= 8'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1)
                                                    : idx_full[IDX_W-1:0];

    assign frac_w = 36'(x_reg[0]) * 36'(MOD2) + 36'(x_reg[1]);

    assign range_err = (req_reg.high_bound < req_reg.low_bound);
    assign range_w   = {req_reg.high_bound[31], req_reg.high_bound}
                     - {req_reg.low_bound[31], req_reg.low_bound} + 33'd1;

    assign est_prod = 64'(dvd_reg[DVD_W-1:EST_LSB]) * 64'(EST_RCP);
    assign est_back = 54'(qe_reg) * 54'(DENOM);

    always_comb begin
        if (rem_reg >= 37'(DENOM)) begin
            fix_q = qe_reg + 17'd1;
            fix_r = 36'(rem_reg - 37'(DENOM));
        end else begin
            fix_q = qe_reg;
            fix_r = rem_reg[35:0];
        end
    end

    assign q_sum = {q_hi_reg, 16'd0} + 33'(fix_q);

    assign result_w = err_reg ? req_reg.low_bound : req_reg.low_bound + acc_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign mem_we   = (state_reg == ST_FILL) || (state_reg == ST_DRAW);
    assign mem_re   = (state_reg == ST_READ);
    assign mem_addr = (state_reg == ST_FILL) ? fill_cnt_reg : idx_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            shuffle_mem[mem_addr] <= frac_w;
        end
        if (mem_re) begin
            rd_data_reg <= shuffle_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_REQ;
            seed_reg     <= SEED_RESET;
            seeded_reg   <= 1'b0;
            fill_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                x_reg[i] <= '0;
            end
        end else begin
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (cfg_wr_en) begin
                        seed_reg   <= cfg_wr_data;
                        seeded_reg <= 1'b0;
                    end
                    if (s_valid) begin
                        req_reg   <= s_data;
                        phase_reg <= (seeded_reg && !cfg_wr_en) ? PH_REQ : PH_SEED_T;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg[0] <= (phase_reg == PH_SEED_T) ? seed_fold : lane_prod[0];
                    for (int i = 1; i < LANES; i++) begin
                        prod_reg[i] <= lane_prod[i];
                    end
                    if (phase_reg == PH_SEED_B) begin
                        x_reg[1] <= (x_reg[0] >= MOD2) ? x_reg[0] - MOD2 : x_reg[0];
                    end
                    if (phase_reg == PH_FILL && fill_cnt_reg == '0) begin
                        x_reg[2] <= (x_reg[0] >= MOD3) ? x_reg[0] - MOD3 : x_reg[0];
                    end
                    state_reg <= ST_QUO;
                end
                ST_QUO: begin
                    for (int i = 0; i < LANES; i++) begin
                        quo_reg[i] <= lane_quo[i];
                    end
                    state_reg <= ST_REM;
                end
                ST_REM: begin
                    for (int i = 0; i < LANES; i++) begin
                        if (lane_en[i]) begin
                            x_reg[i] <= lane_rem[i];
                        end
                    end
                    case (phase_reg)
                        PH_SEED_T: begin
                            phase_reg <= PH_SEED_A;
                            state_reg <= ST_MUL;
                        end
                        PH_SEED_A: begin
                            phase_reg <= PH_SEED_B;
                            state_reg <= ST_MUL;
                        end
                        PH_SEED_B: begin
                            phase_reg    <= PH_FILL;
                            fill_cnt_reg <= '0;
                            state_reg    <= ST_MUL;
                        end
                        PH_FILL: begin
                            state_reg <= ST_FILL;
                        end
                        default: begin
                            state_reg <= ST_IDX;
                        end
                    endcase
                end
                ST_FILL: begin
                    if (fill_cnt_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                        seeded_reg <= 1'b1;
                        phase_reg  <= PH_REQ;
                    end else begin
                        fill_cnt_reg <= fill_cnt_reg + IDX_W'(1);
                    end
                    state_reg <= ST_MUL;
                end
                ST_IDX: begin
                    idx_reg   <= idx_sel;
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    state_reg <= ST_DRAW;
                end
                ST_DRAW: begin
                    drawn_reg <= rd_data_reg;
                    err_reg   <= range_err;
                    n_reg     <= range_w;
                    state_reg <= range_err ? ST_OUT : ST_HMUL;
                end
                ST_HMUL: begin
                    dvd_reg      <= 53'(drawn_reg) * 53'(n_reg[RANGE_W-1:HALF_W]);
                    low_prod_reg <= 52'(drawn_reg) * 52'(n_reg[HALF_W-1:0]);
                    pass_reg     <= 1'b0;
                    state_reg    <= ST_EST;
                end
                ST_EST: begin
                    qe_reg    <= est_prod[EST_SHIFT +: 17];
                    state_reg <= ST_SUB;
                end
                ST_SUB: begin
                    rem_reg   <= 37'(54'(dvd_reg) - est_back);
                    state_reg <= ST_FIX;
                end
                ST_FIX: begin
                    if (!pass_reg) begin
                        q_hi_reg  <= fix_q;
                        dvd_reg   <= {1'b0, fix_r, 16'd0} + 53'(low_prod_reg);
                        pass_reg  <= 1'b1;
                        state_reg <= ST_EST;
                    end else begin
                        acc_reg   <= q_sum[31:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_data_reg.result_value     <= result_w;
                        m_data_reg.sample_numerator <= drawn_reg;
                        m_data_reg.range_error      <= err_reg;
                        state_reg                   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
